// ===== rtl/core/chfp_pkg.sv =====
package chfp_pkg;

   localparam int unsigned FREQ_WIDTH  = 22;
   localparam int unsigned MASK_WIDTH  = 3;
   localparam int unsigned RUN_WIDTH   = 4;
   localparam int unsigned PLUG_WIDTH  = 16;
   localparam int unsigned EVENT_WIDTH = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = FREQ_WIDTH;

   localparam logic [FREQ_WIDTH-1:0] UP_THRESHOLD_RESET  = 22'd800000;
   localparam logic [FREQ_WIDTH-1:0] LOW_THRESHOLD_RESET = 22'd200000;
   localparam logic                  QUAD_MODE_RESET     = 1'b1;
   localparam logic [RUN_WIDTH-1:0]  RUN_THRESHOLD_RESET = 4'd2;

   localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

   localparam logic [1:0] CORE_NONE = 2'd0;
   localparam logic [1:0] CORE_1    = 2'd1;
   localparam logic [1:0] CORE_2    = 2'd2;
   localparam logic [1:0] CORE_3    = 2'd3;

   typedef enum logic [1:0] {
      ACTION_NONE = 2'd0,
      ACTION_UP   = 2'd1,
      ACTION_DOWN = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_UP_THRESHOLD  = 3'd0,
      CSR_LOW_THRESHOLD = 3'd1,
      CSR_QUAD_MODE     = 3'd2,
      CSR_RUN_THRESHOLD = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_WIDTH-1:0] old_freq_khz;
      logic [FREQ_WIDTH-1:0] new_freq_khz;
      logic [MASK_WIDTH-1:0] online_mask;
   } req_type;

   typedef struct packed {
      logic [1:0]            action;
      logic [1:0]            core_index;
      logic [PLUG_WIDTH-1:0] plug_in_total;
      logic [PLUG_WIDTH-1:0] plug_out_total;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_WIDTH-1:0] up_threshold_khz;
      logic [FREQ_WIDTH-1:0] low_threshold_khz;
      logic                  quad_core_mode;
      logic [RUN_WIDTH-1:0]  run_threshold;
   } cfg_type;

   typedef struct packed {
      logic [RUN_WIDTH-1:0] high_run;
      logic [RUN_WIDTH-1:0] low_run;
   } run_state_type;

   typedef struct packed {
      action_type    action;
      logic [1:0]    core_index;
      run_state_type runs;
      logic          plug_in_inc;
      logic          plug_out_inc;
   } decision_type;

   function automatic logic [RUN_WIDTH-1:0] run_sat_inc(input logic [RUN_WIDTH-1:0] value);
      return (value == RUN_MAX) ? value : value + RUN_WIDTH'(1);
   endfunction

endpackage

// ===== rtl/core/chfp_decide.sv =====
module chfp_decide (
   input  chfp_pkg::req_type       req,
   input  chfp_pkg::cfg_type       cfg,
   input  chfp_pkg::run_state_type runs,
   output chfp_pkg::decision_type  decision
);

   logic       high_band;
   logic       low_band;
   logic [1:0] up_pick;
   logic [1:0] down_pick;
   logic [2:0] mask;

   assign mask = req.online_mask;

   assign high_band = (req.old_freq_khz >= cfg.up_threshold_khz) &&
                      (req.new_freq_khz >= cfg.up_threshold_khz);
   assign low_band  = (req.old_freq_khz <= cfg.low_threshold_khz) &&
                      (req.new_freq_khz <= cfg.low_threshold_khz);

   // first offline core, highest first (core 1 only in dual mode)
   always_comb begin
      up_pick = chfp_pkg::CORE_NONE;
      if (cfg.quad_core_mode) begin
         if (!mask[2]) up_pick = chfp_pkg::CORE_3;
         else if (!mask[1]) up_pick = chfp_pkg::CORE_2;
         else if (!mask[0]) up_pick = chfp_pkg::CORE_1;
      end else if (!mask[0]) begin
         up_pick = chfp_pkg::CORE_1;
      end
   end

   // first online core, lowest first (core 1 only in dual mode)
   always_comb begin
      down_pick = chfp_pkg::CORE_NONE;
      if (mask[0]) down_pick = chfp_pkg::CORE_1;
      else if (cfg.quad_core_mode && mask[1]) down_pick = chfp_pkg::CORE_2;
      else if (cfg.quad_core_mode && mask[2]) down_pick = chfp_pkg::CORE_3;
   end

   always_comb begin
      decision.action       = chfp_pkg::ACTION_NONE;
      decision.core_index   = chfp_pkg::CORE_NONE;
      decision.runs         = runs;
      decision.plug_in_inc  = 1'b0;
      decision.plug_out_inc = 1'b0;
      if (high_band) begin
         if ((up_pick != chfp_pkg::CORE_NONE) && (runs.high_run >= cfg.run_threshold)) begin
            decision.action        = chfp_pkg::ACTION_UP;
            decision.core_index    = up_pick;
            decision.plug_in_inc   = 1'b1;
            // run restarts and this event counts as its first
            decision.runs.high_run = chfp_pkg::RUN_WIDTH'(1);
         end else begin
            decision.runs.high_run = chfp_pkg::run_sat_inc(runs.high_run);
         end
      end else if (low_band) begin
         if (down_pick != chfp_pkg::CORE_NONE) begin
            if (runs.low_run >= cfg.run_threshold) begin
               decision.action       = chfp_pkg::ACTION_DOWN;
               decision.core_index   = down_pick;
               decision.plug_out_inc = 1'b1;
               decision.runs.low_run = (down_pick == chfp_pkg::CORE_1) ?
                                       chfp_pkg::RUN_WIDTH'(1) : '0;
            end else begin
               decision.runs.low_run = chfp_pkg::run_sat_inc(runs.low_run);
            end
         end
      end else begin
         decision.runs.high_run = '0;
         decision.runs.low_run  = '0;
      end
   end

endmodule

// ===== rtl/core/cpu_hotplug_freq_policy.sv =====
// Core hotplug policy driven by frequency-change events.
//
// req_valid/req_ready carries one event (old and new frequency, online mask
// of cores 1 to 3); rsp_valid/rsp_ready carries one result per event: the
// action, the core to switch and the running plug-in and plug-out totals.
// Thresholds, quad/dual mode and run threshold go through the csr_ port
// (enable, index, data); the user writes them only while no transaction is in
// flight, and the block itself does not enforce this.
// An accepted event sits in an input register, is decided there by the
// comparators and run logic and lands in the result register once that is
// free, which raises rsp_valid. One event per cycle is sustained while
// rsp_ready stays high; the policy state is updated as an event enters the
// result register, so consecutive events see each other's effect.
//
// When rsp_ready is low a pending result holds, the input register keeps
// its event and accepts no more; with both full req_ready drops. Reset
// empties both registers, clears runs and counters and loads the register
// defaults (800000 kHz, 200000 kHz, quad mode, run threshold 2).
module cpu_hotplug_freq_policy (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  chfp_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output chfp_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_we,
   input  logic [chfp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [chfp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   chfp_pkg::cfg_type       cfg_ff, cfg_in;
   chfp_pkg::req_type       evt_ff;
   logic                    evt_valid_ff, evt_valid_in;
   chfp_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   chfp_pkg::run_state_type runs_ff;
   logic [chfp_pkg::EVENT_WIDTH-1:0] event_total_ff, event_total_in;
   logic [chfp_pkg::PLUG_WIDTH-1:0]  plug_in_count_ff, plug_in_count_in;
   logic [chfp_pkg::PLUG_WIDTH-1:0]  plug_out_count_ff, plug_out_count_in;
   chfp_pkg::decision_type  decision;
   logic                    req_fire;
   logic                    evt_advance;
   logic                    rsp_free;

   chfp_decide u_decide (
      .req      (evt_ff),
      .cfg      (cfg_ff),
      .runs     (runs_ff),
      .decision (decision)
   );

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign evt_advance = evt_valid_ff && rsp_free;
   assign req_ready   = !evt_valid_ff || rsp_free;
   assign req_fire    = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            chfp_pkg::CSR_UP_THRESHOLD:  cfg_in.up_threshold_khz  = csr_wdata;
            chfp_pkg::CSR_LOW_THRESHOLD: cfg_in.low_threshold_khz = csr_wdata;
            chfp_pkg::CSR_QUAD_MODE:     cfg_in.quad_core_mode    = csr_wdata[0];
            chfp_pkg::CSR_RUN_THRESHOLD:
               cfg_in.run_threshold = csr_wdata[chfp_pkg::RUN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      evt_valid_in = evt_valid_ff;
      if (req_fire) evt_valid_in = 1'b1;
      else if (evt_advance) evt_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (evt_advance) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // saturating statistics
   always_comb begin
      event_total_in    = (event_total_ff == '1) ? event_total_ff :
                          event_total_ff + chfp_pkg::EVENT_WIDTH'(1);
      plug_in_count_in  = plug_in_count_ff;
      plug_out_count_in = plug_out_count_ff;
      if (decision.plug_in_inc && (plug_in_count_ff != '1))
         plug_in_count_in = plug_in_count_ff + chfp_pkg::PLUG_WIDTH'(1);
      if (decision.plug_out_inc && (plug_out_count_ff != '1))
         plug_out_count_in = plug_out_count_ff + chfp_pkg::PLUG_WIDTH'(1);
   end

   always_comb begin
      rsp_data_in.action         = decision.action;
      rsp_data_in.core_index     = decision.core_index;
      rsp_data_in.plug_in_total  = plug_in_count_in;
      rsp_data_in.plug_out_total = plug_out_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_threshold_khz  <= chfp_pkg::UP_THRESHOLD_RESET;
         cfg_ff.low_threshold_khz <= chfp_pkg::LOW_THRESHOLD_RESET;
         cfg_ff.quad_core_mode    <= chfp_pkg::QUAD_MODE_RESET;
         cfg_ff.run_threshold     <= chfp_pkg::RUN_THRESHOLD_RESET;
         evt_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         runs_ff           <= '0;
         event_total_ff    <= '0;
         plug_in_count_ff  <= '0;
         plug_out_count_ff <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (evt_advance) begin
            runs_ff           <= decision.runs;
            event_total_ff    <= event_total_in;
            plug_in_count_ff  <= plug_in_count_in;
            plug_out_count_ff <= plug_out_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) evt_ff <= req_data;
      if (evt_advance) rsp_data_ff <= rsp_data_in;
   end

   // a pending result always carries the totals as they stand
   a_totals_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.plug_in_total == plug_in_count_ff) &&
                       (rsp_data_ff.plug_out_total == plug_out_count_ff))
      else $error("result totals differ from counters");

   a_no_core_on_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.action == chfp_pkg::ACTION_NONE) |->
      (rsp_data_ff.core_index == chfp_pkg::CORE_NONE))
      else $error("core index given with no action");

   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      evt_advance && (decision.action == chfp_pkg::ACTION_UP) |=>
      (runs_ff.high_run == chfp_pkg::RUN_WIDTH'(1)))
      else $error("high run did not restart after plug in");

   a_plug_in_step: assert property (@(posedge clock) disable iff (reset)
      evt_advance && decision.plug_in_inc && (plug_in_count_ff != '1) |=>
      (plug_in_count_ff == $past(plug_in_count_ff) + chfp_pkg::PLUG_WIDTH'(1)))
      else $error("plug in count did not step");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      evt_valid_ff && !rsp_free |=> evt_valid_ff && $stable(evt_ff))
      else $error("pending event lost during stall");

endmodule

// ===== verif/tb_cpu_hotplug_freq_policy.sv =====
`timescale 1ns / 100ps

module tb_cpu_hotplug_freq_policy;

   localparam logic [chfp_pkg::FREQ_WIDTH-1:0]      FREQ_TOP = '1;
   localparam logic [chfp_pkg::PLUG_WIDTH-1:0]      PLUG_TOP = '1;
   localparam logic [chfp_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_FIRST = 3'd4;
   localparam int unsigned PHASE_ITEMS = 300;

   typedef enum {BAND_HIGH, BAND_LOW, BAND_EDGE, BAND_NOISE} band_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   chfp_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   chfp_pkg::rsp_type rsp_data;
   logic                                 csr_we    = 1'b0;
   logic [chfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [chfp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // policy copy kept alongside the block
   chfp_pkg::cfg_type policy_cfg = '{chfp_pkg::UP_THRESHOLD_RESET,
                                     chfp_pkg::LOW_THRESHOLD_RESET,
                                     chfp_pkg::QUAD_MODE_RESET,
                                     chfp_pkg::RUN_THRESHOLD_RESET};
   logic [chfp_pkg::RUN_WIDTH-1:0]  high_run_model = '0;
   logic [chfp_pkg::RUN_WIDTH-1:0]  low_run_model  = '0;
   logic [chfp_pkg::PLUG_WIDTH-1:0] plug_in_model  = '0;
   logic [chfp_pkg::PLUG_WIDTH-1:0] plug_out_model = '0;

   chfp_pkg::rsp_type expected_decisions[$];
   chfp_pkg::rsp_type last_decision;

   int unsigned error_count       = 0;
   int unsigned events_accepted   = 0;
   int unsigned decisions_checked = 0;
   int unsigned up_decisions      = 0;
   int unsigned down_decisions    = 0;
   int unsigned settings_applied  = 0;

   bit          send_steady = 1'b0;
   bit          rsp_steady  = 1'b0;
   int unsigned rsp_wait    = 0;

   cpu_hotplug_freq_policy dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [chfp_pkg::RUN_WIDTH-1:0] bump_run(
         input logic [chfp_pkg::RUN_WIDTH-1:0] v);
      return (v == '1) ? v : v + chfp_pkg::RUN_WIDTH'(1);
   endfunction

   function automatic logic [chfp_pkg::PLUG_WIDTH-1:0] bump_plug(
         input logic [chfp_pkg::PLUG_WIDTH-1:0] v);
      return (v == PLUG_TOP) ? v : v + chfp_pkg::PLUG_WIDTH'(1);
   endfunction

   function automatic chfp_pkg::rsp_type decide_hotplug(input chfp_pkg::req_type ev);
      chfp_pkg::rsp_type r;
      logic [1:0]        pick;
      r.action     = chfp_pkg::ACTION_NONE;
      r.core_index = chfp_pkg::CORE_NONE;
      pick         = chfp_pkg::CORE_NONE;
      if (ev.old_freq_khz >= policy_cfg.up_threshold_khz &&
          ev.new_freq_khz >= policy_cfg.up_threshold_khz) begin
         if (policy_cfg.quad_core_mode) begin
            if (!ev.online_mask[2])      pick = chfp_pkg::CORE_3;
            else if (!ev.online_mask[1]) pick = chfp_pkg::CORE_2;
            else if (!ev.online_mask[0]) pick = chfp_pkg::CORE_1;
         end else if (!ev.online_mask[0]) begin
            pick = chfp_pkg::CORE_1;
         end
         if (pick != chfp_pkg::CORE_NONE &&
             high_run_model >= policy_cfg.run_threshold) begin
            r.action       = chfp_pkg::ACTION_UP;
            r.core_index   = pick;
            plug_in_model  = bump_plug(plug_in_model);
            high_run_model = '0;
         end
         high_run_model = bump_run(high_run_model);
      end else if (ev.old_freq_khz <= policy_cfg.low_threshold_khz &&
                   ev.new_freq_khz <= policy_cfg.low_threshold_khz) begin
         if (ev.online_mask[0])
            pick = chfp_pkg::CORE_1;
         else if (policy_cfg.quad_core_mode && ev.online_mask[1])
            pick = chfp_pkg::CORE_2;
         else if (policy_cfg.quad_core_mode && ev.online_mask[2])
            pick = chfp_pkg::CORE_3;
         if (pick != chfp_pkg::CORE_NONE) begin
            if (low_run_model >= policy_cfg.run_threshold) begin
               r.action       = chfp_pkg::ACTION_DOWN;
               r.core_index   = pick;
               plug_out_model = bump_plug(plug_out_model);
               // core 1 going down keeps one step of the run
               low_run_model  = (pick == chfp_pkg::CORE_1) ? chfp_pkg::RUN_WIDTH'(1)
                                                           : chfp_pkg::RUN_WIDTH'(0);
            end else begin
               low_run_model = bump_run(low_run_model);
            end
         end
      end else begin
         high_run_model = '0;
         low_run_model  = '0;
      end
      r.plug_in_total  = plug_in_model;
      r.plug_out_total = plug_out_model;
      return r;
   endfunction

   function automatic int unsigned draw_gap(input bit steady);
      return steady ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic note_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   // result side: random back-pressure, drawn per transaction
   always @(negedge clock) begin
      if (rsp_wait != 0) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      chfp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            decisions_checked++;
            if (expected_decisions.size() == 0) begin
               note_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                       decisions_checked));
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_data.action !== want.action)
                  note_mismatch($sformatf("result %0d action %0d, expected %0d",
                                          decisions_checked, rsp_data.action, want.action));
               if (rsp_data.core_index !== want.core_index)
                  note_mismatch($sformatf("result %0d core %0d, expected %0d",
                                          decisions_checked, rsp_data.core_index,
                                          want.core_index));
               if (rsp_data.plug_in_total !== want.plug_in_total)
                  note_mismatch($sformatf("result %0d plug-in total %0d, expected %0d",
                                          decisions_checked, rsp_data.plug_in_total,
                                          want.plug_in_total));
               if (rsp_data.plug_out_total !== want.plug_out_total)
                  note_mismatch($sformatf("result %0d plug-out total %0d, expected %0d",
                                          decisions_checked, rsp_data.plug_out_total,
                                          want.plug_out_total));
            end
            rsp_wait <= draw_gap(rsp_steady);
            if ($urandom_range(0, 39) == 0) rsp_steady <= !rsp_steady;
         end
         if (req_valid && req_ready) begin
            last_decision = decide_hotplug(req_data);
            expected_decisions.push_back(last_decision);
            events_accepted++;
            if (last_decision.action == chfp_pkg::ACTION_UP)   up_decisions++;
            if (last_decision.action == chfp_pkg::ACTION_DOWN) down_decisions++;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   // with valid still high so a back-to-back transaction keeps it up
   task automatic send_event(input chfp_pkg::req_type ev);
      int unsigned gap;
      gap = draw_gap(send_steady);
      if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_pipeline;
      req_valid <= 1'b0;
      while (expected_decisions.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_csr(input logic [chfp_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [chfp_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      case (index)
         chfp_pkg::CSR_UP_THRESHOLD:  policy_cfg.up_threshold_khz  = value;
         chfp_pkg::CSR_LOW_THRESHOLD: policy_cfg.low_threshold_khz = value;
         chfp_pkg::CSR_QUAD_MODE:     policy_cfg.quad_core_mode    = value[0];
         chfp_pkg::CSR_RUN_THRESHOLD:
            policy_cfg.run_threshold = value[chfp_pkg::RUN_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic set_policy(input logic [chfp_pkg::FREQ_WIDTH-1:0] up_khz,
                             input logic [chfp_pkg::FREQ_WIDTH-1:0] low_khz,
                             input logic [chfp_pkg::CSR_DATA_WIDTH-1:0] quad_data,
                             input logic [chfp_pkg::CSR_DATA_WIDTH-1:0] run_data);
      drain_pipeline();
      write_csr(chfp_pkg::CSR_UP_THRESHOLD, up_khz);
      write_csr(chfp_pkg::CSR_LOW_THRESHOLD, low_khz);
      write_csr(chfp_pkg::CSR_QUAD_MODE, quad_data);
      write_csr(chfp_pkg::CSR_RUN_THRESHOLD, run_data);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   function automatic chfp_pkg::req_type fixed_event(
         input logic [chfp_pkg::FREQ_WIDTH-1:0] old_khz,
         input logic [chfp_pkg::FREQ_WIDTH-1:0] new_khz,
         input logic [chfp_pkg::MASK_WIDTH-1:0] mask);
      chfp_pkg::req_type ev;
      ev.old_freq_khz = old_khz;
      ev.new_freq_khz = new_khz;
      ev.online_mask  = mask;
      return ev;
   endfunction

   function automatic logic [chfp_pkg::FREQ_WIDTH-1:0] near_threshold();
      logic [chfp_pkg::FREQ_WIDTH-1:0] base;
      base = $urandom_range(0, 1) ? policy_cfg.up_threshold_khz
                                  : policy_cfg.low_threshold_khz;
      return base + chfp_pkg::FREQ_WIDTH'($urandom_range(0, 2)) -
             chfp_pkg::FREQ_WIDTH'(1);
   endfunction

   function automatic chfp_pkg::req_type band_event(
         input band_kind_type kind,
         input logic [chfp_pkg::MASK_WIDTH-1:0] mask);
      chfp_pkg::req_type ev;
      ev.online_mask = mask;
      case (kind)
         BAND_HIGH: begin
            ev.old_freq_khz = chfp_pkg::FREQ_WIDTH'($urandom_range(FREQ_TOP,
                                                   policy_cfg.up_threshold_khz));
            ev.new_freq_khz = chfp_pkg::FREQ_WIDTH'($urandom_range(FREQ_TOP,
                                                   policy_cfg.up_threshold_khz));
         end
         BAND_LOW: begin
            ev.old_freq_khz = chfp_pkg::FREQ_WIDTH'($urandom_range(
                                                   policy_cfg.low_threshold_khz, 0));
            ev.new_freq_khz = chfp_pkg::FREQ_WIDTH'($urandom_range(
                                                   policy_cfg.low_threshold_khz, 0));
         end
         BAND_EDGE: begin
            ev.old_freq_khz = near_threshold();
            ev.new_freq_khz = near_threshold();
         end
         default: begin
            ev.old_freq_khz = chfp_pkg::FREQ_WIDTH'($urandom);
            ev.new_freq_khz = chfp_pkg::FREQ_WIDTH'($urandom);
         end
      endcase
      return ev;
   endfunction

   // runs of one band with the online mask following the decisions
   task automatic run_traffic(input int unsigned goal);
      int unsigned                     sent;
      int unsigned                     span;
      int unsigned                     roll;
      band_kind_type                   kind;
      logic [chfp_pkg::MASK_WIDTH-1:0] mask;
      sent = 0;
      mask = chfp_pkg::MASK_WIDTH'($urandom);
      while (sent < goal) begin
         roll = $urandom_range(0, 9);
         if (roll < 4)       kind = BAND_HIGH;
         else if (roll < 8)  kind = BAND_LOW;
         else if (roll == 8) kind = BAND_EDGE;
         else                kind = BAND_NOISE;
         span = $urandom_range(1, 24);
         repeat (span) begin
            // cores switched outside the policy now and then
            if ($urandom_range(0, 9) == 0) mask = chfp_pkg::MASK_WIDTH'($urandom);
            send_event(band_event(kind, mask));
            sent++;
            if (last_decision.action == chfp_pkg::ACTION_UP)
               mask[last_decision.core_index - 2'd1] = 1'b1;
            else if (last_decision.action == chfp_pkg::ACTION_DOWN)
               mask[last_decision.core_index - 2'd1] = 1'b0;
         end
      end
   endtask

   // register defaults straight out of reset
   task automatic test_default_policy;
      send_event(fixed_event(chfp_pkg::UP_THRESHOLD_RESET, chfp_pkg::UP_THRESHOLD_RESET,
                             3'b000));
      send_event(fixed_event(FREQ_TOP, FREQ_TOP, 3'b000));
      send_event(fixed_event(chfp_pkg::UP_THRESHOLD_RESET, FREQ_TOP, 3'b000));
      send_event(fixed_event(chfp_pkg::UP_THRESHOLD_RESET - chfp_pkg::FREQ_WIDTH'(1),
                             chfp_pkg::UP_THRESHOLD_RESET, 3'b100));
      send_event(fixed_event('0, '0, 3'b111));
      send_event(fixed_event(chfp_pkg::LOW_THRESHOLD_RESET, '0, 3'b111));
      send_event(fixed_event(chfp_pkg::LOW_THRESHOLD_RESET, chfp_pkg::LOW_THRESHOLD_RESET,
                             3'b111));
      send_event(fixed_event('0, '0, 3'b110));
      send_event(fixed_event('0, '0, 3'b110));
   endtask

   // every event falls in both bands, high must win
   task automatic test_overlapping_bands;
      set_policy('0, FREQ_TOP, 22'd1, 22'd0);
      send_event(fixed_event('0, '0, 3'b000));
      send_event(fixed_event(FREQ_TOP, FREQ_TOP, 3'b111));
   endtask

   task automatic test_dual_core_mode;
      set_policy(chfp_pkg::UP_THRESHOLD_RESET, chfp_pkg::LOW_THRESHOLD_RESET,
                 22'd0, 22'd1);
      send_event(fixed_event(FREQ_TOP, FREQ_TOP, 3'b110));
      send_event(fixed_event(FREQ_TOP, FREQ_TOP, 3'b110));
      send_event(fixed_event('0, '0, 3'b110));
      send_event(fixed_event('0, '0, 3'b111));
      send_event(fixed_event('0, '0, 3'b111));
   endtask

   // upper data bits of the narrow registers must be dropped
   task automatic test_threshold_extremes;
      set_policy(FREQ_TOP, '0, FREQ_TOP, FREQ_TOP);
      send_event(fixed_event(FREQ_TOP - chfp_pkg::FREQ_WIDTH'(1), FREQ_TOP, 3'b000));
      send_event(fixed_event(FREQ_TOP, FREQ_TOP, 3'b000));
      send_event(fixed_event('0, 22'd1, 3'b111));
      send_event(fixed_event('0, '0, 3'b111));
   endtask

   task automatic test_spare_registers;
      int i;
      drain_pipeline();
      for (i = int'(CSR_SPARE_FIRST); i < 2 ** chfp_pkg::CSR_INDEX_WIDTH; i++)
         write_csr(chfp_pkg::CSR_INDEX_WIDTH'(i), chfp_pkg::CSR_DATA_WIDTH'($urandom));
      csr_we <= 1'b0;
      send_event(fixed_event('0, '0, 3'b111));
   endtask

   task automatic test_random_traffic;
      set_policy(chfp_pkg::UP_THRESHOLD_RESET, chfp_pkg::LOW_THRESHOLD_RESET,
                 22'd1, 22'd2);
      run_traffic(PHASE_ITEMS);
      set_policy(FREQ_TOP, '0, 22'd1, 22'd15);
      run_traffic(PHASE_ITEMS);
      set_policy('0, FREQ_TOP, 22'd0, 22'd0);
      run_traffic(PHASE_ITEMS);
      set_policy(chfp_pkg::FREQ_WIDTH'($urandom_range(FREQ_TOP, FREQ_TOP / 2)),
                 chfp_pkg::FREQ_WIDTH'($urandom_range(FREQ_TOP / 2 - 1, 0)),
                 chfp_pkg::CSR_DATA_WIDTH'($urandom), chfp_pkg::CSR_DATA_WIDTH'($urandom));
      run_traffic(PHASE_ITEMS);
      set_policy(chfp_pkg::FREQ_WIDTH'($urandom), chfp_pkg::FREQ_WIDTH'($urandom),
                 chfp_pkg::CSR_DATA_WIDTH'($urandom), chfp_pkg::CSR_DATA_WIDTH'($urandom));
      run_traffic(PHASE_ITEMS);
      set_policy(chfp_pkg::FREQ_WIDTH'($urandom_range(FREQ_TOP, FREQ_TOP / 2)),
                 chfp_pkg::FREQ_WIDTH'($urandom_range(FREQ_TOP / 2 - 1, 0)),
                 22'd0, chfp_pkg::CSR_DATA_WIDTH'($urandom_range(0, 4)));
      run_traffic(PHASE_ITEMS);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_policy();
      test_overlapping_bands();
      test_dual_core_mode();
      test_threshold_extremes();
      test_spare_registers();
      test_random_traffic();
      drain_pipeline();
      repeat (8) @(negedge clock);
      $display("covered %0d events under %0d register settings, %0d results checked",
               events_accepted, settings_applied + 1, decisions_checked);
      $display("policy called for %0d core-up and %0d core-down switches, %0d mismatches",
               up_decisions, down_decisions, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
